/* sv/jspf_pkg.sv */
// ----------------------------------------------------------------------------
// jspf_pkg
// shared types, field offsets and arithmetic helpers of the joint servo block
// ----------------------------------------------------------------------------
`default_nettype none

package jspf_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_FF_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_PERIOD = 3'd5;

    localparam logic [15:0] PERIOD_RESET = 16'd131;

    // input beat layout
    localparam int S_TDATA_W = 200;
    localparam int S_TUSER_W = 3;
    localparam int JI_LSB    = 0;
    localparam int TGT_LSB   = 5;
    localparam int MEAS_LSB  = 37;
    localparam int BIAS_LSB  = 69;
    localparam int KV_LSB    = 101;
    localparam int FLO_LSB   = 133;
    localparam int FHI_LSB   = 165;
    localparam int HJ_BIT    = 0;
    localparam int HD_BIT    = 1;
    localparam int FL_BIT    = 2;

    // output beat layout
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 1;

    // arithmetic units
    localparam int DIV_DW = 80;
    localparam int DIV_QW = 48;
    localparam int DIV_SW = 31;
    localparam int MUL_W  = 48;
    localparam int PROD_W = 96;

    localparam logic [47:0] EMAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] EMIN = 48'h8000_0000_0000;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_PREP,
        OP_DIV_RATIO,
        OP_RATIO_TAKE,
        OP_DIV_WIND,
        OP_WIND_TAKE,
        OP_INT_MUL,
        OP_INT_ADD,
        OP_MUL_OFF,
        OP_CLAMP,
        OP_MUL_GRAV,
        OP_GRAV_TAKE,
        OP_MUL_VK,
        OP_VK_TAKE,
        OP_DIV_VEL,
        OP_VDIV_TAKE,
        OP_MUL_VEL,
        OP_VEL_TAKE,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic hj;
        logic int_en;
        logic ff_en;
        logic vel_en;
        logic dirty;
        logic mul_busy;
        logic div_busy;
        logic out_free;
    } status_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    function automatic logic [47:0] mag48(input logic signed [47:0] x);
        return x[47] ? 48'(-x) : 48'(x);
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
        logic signed [47:0] r;
        if (x > $signed({2'b00, EMAX})) r = $signed(EMAX);
        else if (x < $signed({2'b11, EMIN})) r = $signed(EMIN);
        else r = x[47:0];
        return r;
    endfunction

    // product magnitude >> 16, saturated to 48 signed bits, sign applied
    function automatic logic signed [47:0] mulsat16(input logic [PROD_W-1:0] p,
                                                    input logic neg);
        logic [47:0] lim;
        logic [47:0] m;
        lim = neg ? EMIN : EMAX;
        if ((p[95:64] != 32'd0) || (p[63:16] > lim)) m = lim;
        else m = p[63:16];
        return neg ? $signed(48'(-m)) : $signed(m);
    endfunction

endpackage

`default_nettype wire

/* sv/jspf_mul.sv */
// ----------------------------------------------------------------------------
// jspf_mul
// 48 x 48 magnitude multiplier, one 16-bit digit of b per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module jspf_mul
    import jspf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [MUL_W-1:0]  a,
    input  wire logic [MUL_W-1:0]  b,
    output logic                   busy,
    output logic [PROD_W-1:0]      prod
);

    logic [MUL_W-1:0]  a_reg;
    logic [MUL_W-1:0]  bsh_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [1:0]        cnt_reg;
    logic              busy_reg;
    logic [63:0]       pp;

    assign pp = a_reg * bsh_reg[47:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 2'd3;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 2'd1;
            if (cnt_reg == 2'd1) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            bsh_reg <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= {acc_reg[PROD_W-17:0], 16'd0} + PROD_W'(pp);
            bsh_reg <= {bsh_reg[MUL_W-17:0], 16'd0};
        end
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

/* sv/jspf_div.sv */
// ----------------------------------------------------------------------------
// jspf_div
// restoring divider, one quotient bit per cycle, 48 quotient bits
// ----------------------------------------------------------------------------
`default_nettype none

module jspf_div
    import jspf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_DW-1:0] dividend,
    input  wire logic [DIV_SW-1:0] divisor,
    output logic                   busy,
    output logic [DIV_QW-1:0]      quotient
);

    logic [DIV_SW-1:0] rem_reg;
    logic [DIV_SW-1:0] dvs_reg;
    logic [DIV_QW-1:0] low_reg;
    logic [DIV_QW-1:0] q_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic [DIV_SW:0]   remsh;
    logic              fits;

    assign remsh = {rem_reg, low_reg[DIV_QW-1]};
    assign fits  = remsh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(DIV_QW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[DIV_QW +: DIV_SW];
            low_reg <= dividend[DIV_QW-1:0];
            dvs_reg <= divisor;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? DIV_SW'(remsh - {1'b0, dvs_reg}) : remsh[DIV_SW-1:0];
            low_reg <= {low_reg[DIV_QW-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_QW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

/* sv/jspf_ctrl.sv */
// ----------------------------------------------------------------------------
// jspf_ctrl
// sequencer that steps one joint through the servo datapath
// ----------------------------------------------------------------------------
`default_nettype none

module jspf_ctrl
    import jspf_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_PREP, ST_RATIO, ST_RATIO_W, ST_WIND, ST_WIND_W,
        ST_INT_MUL, ST_INT_ADD, ST_OFF, ST_OFF_W, ST_GRAV, ST_GRAV_W,
        ST_VK, ST_VK_W, ST_VDIV, ST_VDIV_W, ST_VMUL, ST_VMUL_W, ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd.load   = s_tvalid && ready_reg;
        cmd.op     = OP_IDLE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready_reg) state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.op = OP_PREP;
                if (status.hj && status.int_en)
                    state_next = status.dirty ? ST_RATIO : ST_INT_MUL;
                else
                    state_next = status.ff_en ? ST_GRAV : ST_FIN;
            end
            ST_RATIO: begin
                cmd.op     = OP_DIV_RATIO;
                state_next = ST_RATIO_W;
            end
            ST_RATIO_W: begin
                if (!status.div_busy) begin
                    cmd.op     = OP_RATIO_TAKE;
                    state_next = ST_WIND;
                end
            end
            ST_WIND: begin
                cmd.op     = OP_DIV_WIND;
                state_next = ST_WIND_W;
            end
            ST_WIND_W: begin
                if (!status.div_busy) begin
                    cmd.op     = OP_WIND_TAKE;
                    state_next = ST_INT_MUL;
                end
            end
            ST_INT_MUL: begin
                cmd.op     = OP_INT_MUL;
                state_next = ST_INT_ADD;
            end
            ST_INT_ADD: begin
                cmd.op     = OP_INT_ADD;
                state_next = ST_OFF;
            end
            ST_OFF: begin
                cmd.op     = OP_MUL_OFF;
                state_next = ST_OFF_W;
            end
            ST_OFF_W: begin
                if (!status.mul_busy) begin
                    cmd.op     = OP_CLAMP;
                    state_next = status.ff_en ? ST_GRAV : ST_FIN;
                end
            end
            ST_GRAV: begin
                cmd.op     = OP_MUL_GRAV;
                state_next = ST_GRAV_W;
            end
            ST_GRAV_W: begin
                if (!status.mul_busy) begin
                    cmd.op     = OP_GRAV_TAKE;
                    state_next = status.vel_en ? ST_VK : ST_FIN;
                end
            end
            ST_VK: begin
                cmd.op     = OP_MUL_VK;
                state_next = ST_VK_W;
            end
            ST_VK_W: begin
                if (!status.mul_busy) begin
                    cmd.op     = OP_VK_TAKE;
                    state_next = ST_VDIV;
                end
            end
            ST_VDIV: begin
                cmd.op     = OP_DIV_VEL;
                state_next = ST_VDIV_W;
            end
            ST_VDIV_W: begin
                if (!status.div_busy) begin
                    cmd.op     = OP_VDIV_TAKE;
                    state_next = ST_VMUL;
                end
            end
            ST_VMUL: begin
                cmd.op     = OP_MUL_VEL;
                state_next = ST_VMUL_W;
            end
            ST_VMUL_W: begin
                if (!status.mul_busy) begin
                    cmd.op     = OP_VEL_TAKE;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE) && !(state_reg == ST_IDLE && cmd.load);
        end
    end

    assign s_tready = ready_reg;

endmodule

`default_nettype wire

/* sv/jspf_dp.sv */
// ----------------------------------------------------------------------------
// jspf_dp
// servo datapath: config registers, per-joint state, arithmetic, result beat
// ----------------------------------------------------------------------------
`default_nettype none

module jspf_dp
    import jspf_pkg::*;
#(
    parameter int JOINTS      = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [M_TUSER_W-1:0]       m_tuser,
    input  wire cmd_t                  cmd,
    output status_t                    status
);

    localparam int IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

    function automatic logic [31:0] sat_vw(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > VMAX) r = VMAX;
        else if (v < VMIN) r = VMIN;
        else r = v;
        return r[31:0];
    endfunction

    // configuration
    logic [30:0]        kp_reg, ki_reg, lim_reg;
    logic signed [31:0] gg_reg, vff_reg;
    logic [15:0]        per_reg;
    logic               dirty_reg, hp_reg;

    // per-joint state
    logic [47:0]        ei_mem [JOINTS];
    logic [31:0]        pv_mem [JOINTS];
    logic [JOINTS-1:0]  ei_vld_reg, pv_vld_reg;
    logic [47:0]        ei_rd_reg;
    logic [31:0]        pv_rd_reg;
    logic               ei_v_rd_reg, pv_v_rd_reg;

    // latched item
    logic [IDX_W-1:0]   addr_reg;
    logic               inrange_reg;
    logic signed [31:0] tgt_reg, meas_reg, bias_reg, kv_reg, flo_reg, fhi_reg;
    logic               hj_reg, hd_reg, fl_reg, fe_reg;

    // working registers
    logic signed [47:0] ei_reg;
    logic signed [31:0] pv_reg;
    logic [47:0]        ratio_reg, wl_reg;
    logic [61:0]        wprod_reg;
    logic               ovf_reg, neg_reg, dneg_reg;
    logic signed [49:0] prodp_reg, f_reg;
    logic signed [31:0] off_reg;
    logic signed [47:0] vk_reg, qd_reg;

    // result beat
    logic               m_valid_reg;
    logic [63:0]        m_data_reg;
    logic               m_user_reg;

    logic [4:0]         ld_joint;
    logic [IDX_W-1:0]   ld_addr;
    logic               ld_inrange;
    logic               mul_start, mul_busy, div_start, div_busy;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic               mul_neg;
    logic [PROD_W-1:0]  prod;
    logic [DIV_DW-1:0]  div_dd;
    logic [DIV_SW-1:0]  div_ds;
    logic [DIV_QW-1:0]  div_q;
    logic signed [32:0] diff;
    logic signed [32:0] err;
    logic [32:0]        diff_mag;
    logic               int_en, vel_en, out_free;
    logic               clamp_big;
    logic signed [49:0] f_lim;
    logic [31:0]        pos_out, ff_out;
    logic               wr_ei, wr_pv;

    assign ld_joint   = s_tdata[JI_LSB +: 5];
    assign ld_addr    = IDX_W'(ld_joint);
    assign ld_inrange = 32'(ld_joint) < JOINTS;

    assign int_en   = (kp_reg != 31'd0) && (ki_reg != 31'd0);
    assign vel_en   = (vff_reg != 32'sd0) && hp_reg && (per_reg != 16'd0);
    assign out_free = !m_valid_reg || m_tready;

    assign diff     = {tgt_reg[31], tgt_reg} - {pv_reg[31], pv_reg};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign err      = {tgt_reg[31], tgt_reg} - {meas_reg[31], meas_reg};

    assign status.hj       = hj_reg;
    assign status.int_en   = int_en;
    assign status.ff_en    = hj_reg && hd_reg;
    assign status.vel_en   = vel_en;
    assign status.dirty    = dirty_reg;
    assign status.mul_busy = mul_busy;
    assign status.div_busy = div_busy;
    assign status.out_free = out_free;

    // unit operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        div_start = 1'b0;
        div_dd    = '0;
        div_ds    = '0;
        unique case (cmd.op)
            OP_MUL_OFF: begin
                mul_start = 1'b1;
                mul_a     = ratio_reg;
                mul_b     = mag48(ei_reg);
                mul_neg   = ei_reg[47];
            end
            OP_MUL_GRAV: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(mag32(gg_reg));
                mul_b     = MUL_W'(mag32(bias_reg));
                mul_neg   = gg_reg[31] ^ bias_reg[31];
            end
            OP_MUL_VK: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(mag32(vff_reg));
                mul_b     = MUL_W'(mag32(kv_reg));
                mul_neg   = vff_reg[31] ^ kv_reg[31];
            end
            OP_MUL_VEL: begin
                mul_start = 1'b1;
                mul_a     = mag48(vk_reg);
                mul_b     = mag48(qd_reg);
                mul_neg   = vk_reg[47] ^ qd_reg[47];
            end
            OP_DIV_RATIO: begin
                div_start = 1'b1;
                div_dd    = DIV_DW'({ki_reg, 16'd0});
                div_ds    = kp_reg;
            end
            OP_DIV_WIND: begin
                div_start = 1'b1;
                div_dd    = DIV_DW'({wprod_reg, 16'd0});
                div_ds    = ki_reg;
            end
            OP_DIV_VEL: begin
                div_start = 1'b1;
                div_dd    = DIV_DW'({diff_mag, 16'd0});
                div_ds    = DIV_SW'(per_reg);
            end
            default: ;
        endcase
    end

    jspf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .prod    (prod)
    );

    jspf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dd),
        .divisor  (div_ds),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // offset bound check on the integral product
    assign clamp_big = (prod[95:63] != 33'd0) || (prod[62:32] > lim_reg);

    // result of the finish step
    always_comb begin
        f_lim = f_reg;
        if (fl_reg) begin
            if (f_lim > 50'(fhi_reg)) f_lim = 50'(fhi_reg);
            if (f_lim < 50'(flo_reg)) f_lim = 50'(flo_reg);
        end
        pos_out = sat_vw(64'(tgt_reg) + 64'(off_reg));
        ff_out  = (hj_reg && hd_reg) ? sat_vw(64'(f_lim)) : 32'd0;
    end

    assign wr_ei = (cmd.op == OP_CLAMP) && inrange_reg;
    assign wr_pv = (cmd.op == OP_FINISH) && inrange_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg      <= '0;
            ki_reg      <= '0;
            lim_reg     <= '0;
            gg_reg      <= '0;
            vff_reg     <= '0;
            per_reg     <= PERIOD_RESET;
            dirty_reg   <= 1'b1;
            hp_reg      <= 1'b0;
            ei_vld_reg  <= '0;
            pv_vld_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_PROP_GAIN: begin
                        kp_reg    <= cfg_data[30:0];
                        dirty_reg <= 1'b1;
                    end
                    CFG_INTEGRAL_GAIN: begin
                        ki_reg    <= cfg_data[30:0];
                        dirty_reg <= 1'b1;
                    end
                    CFG_OFFSET_LIMIT: begin
                        lim_reg   <= cfg_data[30:0];
                        dirty_reg <= 1'b1;
                    end
                    CFG_GRAVITY_GAIN:   gg_reg  <= cfg_data;
                    CFG_VEL_FF_GAIN:    vff_reg <= cfg_data;
                    CFG_CONTROL_PERIOD: per_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_WIND_TAKE) dirty_reg <= 1'b0;
            if (wr_ei) ei_vld_reg[addr_reg] <= 1'b1;
            if (wr_pv) pv_vld_reg[addr_reg] <= 1'b1;
            if (cmd.op == OP_FINISH && fe_reg) hp_reg <= 1'b1;
            if (cmd.op == OP_FINISH) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // per-joint memories, registered read at accept
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ei_rd_reg   <= ei_mem[ld_addr];
            pv_rd_reg   <= pv_mem[ld_addr];
            ei_v_rd_reg <= ei_vld_reg[ld_addr];
            pv_v_rd_reg <= pv_vld_reg[ld_addr];
        end
        if (wr_ei) ei_mem[addr_reg] <= clamp_big ? (ei_reg[47] ? 48'(-wl_reg) : wl_reg)
                                                 : ei_reg;
        if (wr_pv) pv_mem[addr_reg] <= tgt_reg;
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg    <= ld_addr;
            inrange_reg <= ld_inrange;
            tgt_reg     <= s_tdata[TGT_LSB +: 32];
            meas_reg    <= s_tdata[MEAS_LSB +: 32];
            bias_reg    <= s_tdata[BIAS_LSB +: 32];
            kv_reg      <= s_tdata[KV_LSB +: 32];
            flo_reg     <= s_tdata[FLO_LSB +: 32];
            fhi_reg     <= s_tdata[FHI_LSB +: 32];
            hj_reg      <= s_tuser[HJ_BIT];
            hd_reg      <= s_tuser[HD_BIT];
            fl_reg      <= s_tuser[FL_BIT];
            fe_reg      <= s_tlast;
        end
        if (mul_start) neg_reg <= mul_neg;
        if (cmd.op == OP_DIV_VEL) dneg_reg <= diff[32];
        unique case (cmd.op)
            OP_PREP: begin
                ei_reg  <= (inrange_reg && ei_v_rd_reg) ? ei_rd_reg : 48'sd0;
                pv_reg  <= (inrange_reg && pv_v_rd_reg) ? pv_rd_reg : 32'sd0;
                off_reg <= 32'sd0;
                f_reg   <= 50'sd0;
            end
            OP_RATIO_TAKE: begin
                ratio_reg <= div_q;
                wprod_reg <= lim_reg * kp_reg;
            end
            OP_DIV_WIND: ovf_reg <= wprod_reg[61:32] >= ki_reg;
            OP_WIND_TAKE: wl_reg <= (ovf_reg || div_q[47]) ? EMAX : div_q;
            OP_INT_MUL: prodp_reg <= 50'(err * $signed({1'b0, per_reg}));
            OP_INT_ADD: ei_reg <= sat48({ei_reg[47], ei_reg[47], ei_reg} + prodp_reg);
            OP_CLAMP: begin
                if (clamp_big) begin
                    off_reg <= neg_reg ? -$signed({1'b0, lim_reg}) : $signed({1'b0, lim_reg});
                    ei_reg  <= neg_reg ? $signed(48'(-wl_reg)) : $signed(wl_reg);
                end else begin
                    off_reg <= neg_reg ? -$signed({1'b0, prod[62:32]})
                                       : $signed({1'b0, prod[62:32]});
                end
            end
            OP_GRAV_TAKE: f_reg <= 50'(mulsat16(prod, neg_reg));
            OP_VK_TAKE:   vk_reg <= mulsat16(prod, neg_reg);
            OP_VDIV_TAKE: begin
                if (!dneg_reg) qd_reg <= div_q[47] ? $signed(EMAX) : $signed(div_q);
                else if (div_q[47]) qd_reg <= $signed(EMIN);
                else qd_reg <= $signed(48'(-div_q));
            end
            OP_VEL_TAKE: f_reg <= f_reg + 50'(mulsat16(prod, neg_reg));
            OP_FINISH: begin
                m_data_reg <= {ff_out, pos_out};
                m_user_reg <= hj_reg && hd_reg;
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

/* sv/joint_servo_pi_feedforward.sv */
// ----------------------------------------------------------------------------
// joint_servo_pi_feedforward
// per-joint PI position offset with anti-windup plus feedforward force
// ----------------------------------------------------------------------------
// Each input beat addresses one joint and yields one result beat. Work is done
// one joint at a time by a sequencer driving a shared 48x48 multiplier (which
// works through b in 16-bit digits) and a shared restoring divider (one
// quotient bit a cycle, 48 quotient bits). A joint without an actuator goes
// straight from the prepare step to the finish step; the integral path, gravity
// feedforward and velocity feedforward each add steps, the last with a divide
// by the control period. The first integrating item after a write to the
// proportional or integral gain or the offset limit first runs two divides
// that refresh the cached gain ratio and windup level. A new beat is taken as
// soon as the previous result sits in the output register, and that result
// may wait there while the next joint is being worked on; a joint whose result
// is ready waits in its last step until the output register is free. Config
// writes are always ready and must only be issued while the block is idle.
// Per-joint state sits in small memories with valid bits cleared by reset, so
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_servo_pi_feedforward
    import jspf_pkg::*;
#(
    parameter int JOINTS      = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]           cfg_data,
    // input beats
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // joint_index, target_pos, measured_pos, bias_force, actuator_damping,
    // force_low, force_high, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // has_joint, has_dof, force_limited
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    // frame_end
    input  wire logic                  s_tlast,
    // result beats
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // position_command, feedforward_force
    output logic [M_TDATA_W-1:0]       m_tdata,
    // feedforward_valid
    output logic [M_TUSER_W-1:0]       m_tuser
);

    cmd_t    cmd;
    status_t status;

    // config registers can always take a write
    assign cfg_ready = 1'b1;

    // sequencer
    jspf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath with state memories and result register
    jspf_dp #(
        .JOINTS      (JOINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef SYNTHESIS
    // one joint in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a joint is in work");

    // a new result only comes out of a joint that was in work
    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result beat without an item in work");

    // force is zero whenever feedforward does not apply
    a_force_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[63:32] == 32'd0)
        else $error("nonzero force with feedforward invalid");
`endif

endmodule

`default_nettype wire
